// ----- sv/circular_fifo_queue_macros.svh -----
// assertion macros used by the checker file
`ifndef CIRCULAR_FIFO_QUEUE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CFQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cfq_pkg.sv -----
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared sizes, operation codes, command struct and helpers of the ring FIFO.
// ----------------------------------------------------------------------------
package cfq_pkg;

  // ring storage size and derived widths
  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int KIND_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_QRY = 2'd2,
    KIND_BAD = 2'd3
  } kind_e;

  // controller to datapath commands
  typedef struct packed {
    logic op_en;  // apply the operation of the accepted word
    logic rd_en;  // read front and rear entries
    logic ld_en;  // load the output register
  } cfq_cmd_t;

  // capacity in use: zero acts as one, anything above DEPTH as DEPTH
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (cap == '0) begin
      res = CNT_W'(1);
    end else if (int'(cap) > DEPTH) begin
      res = CNT_W'(DEPTH);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

  // pointer step with wrap at the capacity in use
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt >= cap) ? '0 : PTR_W'(nxt);
  endfunction

endpackage

// ----- sv/cfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfq_ctrl
// Sequencer: accept, read the ring, load the output register.
// ----------------------------------------------------------------------------
module cfq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cfq_pkg::cfq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // output register can take a new word
  assign slot_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op_en = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          cmd_o.ld_en = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/cfq_dp.sv -----
// ----------------------------------------------------------------------------
// cfq_dp
// Ring storage, pointers, fill count, capacity register and output register.
// ----------------------------------------------------------------------------
module cfq_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfq_pkg::cfq_cmd_t                cmd_i,
  input  logic                             cfg_we_i,
  input  logic [cfq_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  logic [cfq_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [cfq_pkg::DATA_W-1:0] value_i,
  output logic                             accepted_o,
  output logic signed [cfq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [cfq_pkg::DATA_W-1:0] rear_value_o,
  output logic [cfq_pkg::COUNT_W-1:0]      count_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);

  logic [cfq_pkg::DATA_W-1:0] mem_q [cfq_pkg::DEPTH];

  logic [cfq_pkg::CAP_W-1:0] cap_q;
  logic [cfq_pkg::PTR_W-1:0] head_q, head_d;
  logic [cfq_pkg::PTR_W-1:0] tail_q, tail_d;
  logic [cfq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      acc_q, acc_d;
  logic                      wr_en;
  logic [cfq_pkg::CNT_W-1:0] cap_eff;
  logic [cfq_pkg::PTR_W-1:0] rear_idx;
  logic [cfq_pkg::DATA_W-1:0] front_q, rear_q;
  cfq_pkg::kind_e            kind;

  assign cap_eff = cfq_pkg::eff_cap(cap_q);
  assign kind    = cfq_pkg::kind_e'(kind_i);

  // operation decode
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    acc_d  = 1'b0;
    wr_en  = 1'b0;
    case (kind)
      cfq_pkg::KIND_ENQ: begin
        if (cnt_q < cap_eff) begin
          wr_en  = 1'b1;
          tail_d = cfq_pkg::advance(tail_q, cap_eff);
          cnt_d  = cnt_q + cfq_pkg::CNT_W'(1);
          acc_d  = 1'b1;
        end
      end
      cfq_pkg::KIND_DEQ: begin
        if (cnt_q != '0) begin
          head_d = cfq_pkg::advance(head_q, cap_eff);
          cnt_d  = cnt_q - cfq_pkg::CNT_W'(1);
          acc_d  = 1'b1;
        end
      end
      cfq_pkg::KIND_QRY: begin
        acc_d = 1'b1;
      end
      default: begin
        acc_d = 1'b0;
      end
    endcase
  end

  // pointer, count and capacity registers; a capacity write empties the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= cfq_pkg::CAP_RST;
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_wdata_i;
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.op_en) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // accept flag of the word in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.op_en) begin
      acc_q <= acc_d;
    end
  end

  // newest entry sits just behind the tail
  assign rear_idx = (tail_q == '0) ? cfq_pkg::PTR_W'(cap_eff - cfq_pkg::CNT_W'(1))
                                   : tail_q - cfq_pkg::PTR_W'(1);

  // ring storage, one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.op_en && wr_en) begin
      mem_q[tail_q] <= value_i;
    end
    if (cmd_i.rd_en) begin
      front_q <= mem_q[head_q];
      rear_q  <= mem_q[rear_idx];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_en) begin
      accepted_o    <= acc_q;
      front_value_o <= (cnt_q == '0) ? '1 : front_q;
      rear_value_o  <= (cnt_q == '0) ? '1 : rear_q;
      count_o       <= cfq_pkg::COUNT_W'(cnt_q);
      is_empty_o    <= (cnt_q == '0);
      is_full_o     <= (cnt_q == cap_eff);
    end
  end

endmodule

// ----- sv/circular_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring-buffer FIFO of signed 32-bit values with a programmable capacity.
// ----------------------------------------------------------------------------
// Each input word is an enqueue, a dequeue or a status query, and each one
// returns exactly one output word with the accept flag, the front and rear
// values (-1 when empty), the fill count and the empty/full flags after the
// operation. One word is in flight at a time. The accepting step applies the
// operation, the read step does the registered read of the ring storage and
// the load step then loads the output register. A new input word is taken
// only after the previous word has been loaded into the output register.
// A finished output word may wait for out_ready_i while the next
// input word is already taken. That word then waits in the load step until
// the output register is free, and the input stalls meanwhile.
// Writing the capacity register empties the queue; capacity 0 acts as 1 and
// values above the ring depth act as the depth.
module circular_fifo_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cfq_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cfq_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [cfq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic signed [cfq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [cfq_pkg::DATA_W-1:0] rear_value_o,
  output logic [cfq_pkg::COUNT_W-1:0]       count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  cfq_pkg::cfq_cmd_t cmd;

  // sequencer
  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // storage and result datapath
  cfq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .accepted_o    (accepted_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

endmodule

// ----- sv/cfq_checker.sv -----
// ----------------------------------------------------------------------------
// cfq_checker
// Port-level checks of the ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_fifo_queue_macros.svh"

module cfq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              accepted_o,
  input logic signed [cfq_pkg::DATA_W-1:0] front_value_o,
  input logic signed [cfq_pkg::DATA_W-1:0] rear_value_o,
  input logic [cfq_pkg::COUNT_W-1:0]       count_o,
  input logic                              is_empty_o
);

  // empty flag agrees with the count
  `CFQ_ASSERT_NOW(a_empty_count, clk_i, rst_ni, out_valid_o, is_empty_o == (count_o == '0), "empty flag and count disagree")

  // empty queue shows -1 at both ends
  `CFQ_ASSERT_NOW(a_empty_values, clk_i, rst_ni, out_valid_o && is_empty_o, (front_value_o == '1) && (rear_value_o == '1), "empty queue must report -1")

  // one word in flight: no new acceptance right after one
  `CFQ_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "second word accepted while one is in flight")

  // stalled output word holds
  `CFQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(accepted_o) && $stable(front_value_o) && $stable(count_o), "stalled output word changed")

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .accepted_o    (accepted_o),
  .front_value_o (front_value_o),
  .rear_value_o  (rear_value_o),
  .count_o       (count_o),
  .is_empty_o    (is_empty_o)
);

// ----- tb/sv/tb_circular_fifo_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue
// Self-checking bench for the ring FIFO with a programmable capacity.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the ring, the pointers and the capacity.
// Every accepted input word is turned into the expected status word, and
// every output word is compared field by field with the oldest expected
// one. A directed burst covers the empty and full corners, the wrap and the
// value extremes. Random phases then sweep the capacity, including zero and
// values above the ring depth, under several idling patterns and one long
// receiver hold-off.
module tb_circular_fifo_queue;
  import cfq_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_WORDS    = 104;
  localparam int DRAIN_CYCLES   = 8;

  // idling patterns of the random phases
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // one output word of the block
  typedef struct packed {
    logic                     accepted;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] rear;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     is_full;
  } fifo_status_t;

  // ring state mirror and store of expected status words
  class fifo_scoreboard;
    logic signed [DATA_W-1:0] ring [DEPTH];
    int                       head;
    int                       tail;
    int                       fill;
    logic [CAP_W-1:0]         cap_reg;
    fifo_status_t             expected_q [$];
    int                       errors;

    function new();
      cap_reg = CAP_RST;
      head    = 0;
      tail    = 0;
      fill    = 0;
      errors  = 0;
    endfunction

    // a capacity write empties the queue but keeps the ring contents
    function void set_capacity(logic [CAP_W-1:0] cap);
      cap_reg = cap;
      head    = 0;
      tail    = 0;
      fill    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted word and queue the status it must produce
    function void note_word(kind_e op, logic signed [DATA_W-1:0] v);
      fifo_status_t e;
      int           cap;
      int           rear_idx;
      cap = (cap_reg == '0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
      e = '0;
      case (op)
        KIND_ENQ: begin
          if (fill < cap) begin
            ring[tail] = v;
            tail = (tail + 1 >= cap) ? 0 : tail + 1;
            fill++;
            e.accepted = 1'b1;
          end
        end
        KIND_DEQ: begin
          if (fill != 0) begin
            head = (head + 1 >= cap) ? 0 : head + 1;
            fill--;
            e.accepted = 1'b1;
          end
        end
        KIND_QRY: e.accepted = 1'b1;
        default: e.accepted = 1'b0;
      endcase
      e.front = -1;
      e.rear  = -1;
      if (fill != 0) begin
        rear_idx = (tail == 0) ? cap - 1 : tail - 1;
        e.front  = ring[head];
        e.rear   = ring[rear_idx];
      end
      e.count    = COUNT_W'(fill);
      e.is_empty = (fill == 0);
      e.is_full  = (fill == cap);
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void compare_field(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    // compare one output word with the oldest expectation
    function void check_word(fifo_status_t got);
      fifo_status_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: output word with nothing expected, actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare_field("accepted", e.accepted, got.accepted);
      compare_field("front_value", e.front, got.front);
      compare_field("rear_value", e.rear, got.rear);
      compare_field("count", e.count, got.count);
      compare_field("is_empty", e.is_empty, got.is_empty);
      compare_field("is_full", e.is_full, got.is_full);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CAP_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [KIND_W-1:0]        kind_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     accepted_o;
  logic signed [DATA_W-1:0] front_value_o;
  logic signed [DATA_W-1:0] rear_value_o;
  logic [COUNT_W-1:0]       count_o;
  logic                     is_empty_o;
  logic                     is_full_o;

  fifo_status_t   got_word;
  fifo_scoreboard fifo_sb = new();
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             hold_request = 0;
  int             hold_left = 0;
  int             quiet_cycles = 0;

  circular_fifo_queue u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_o   (accepted_o),
    .front_value_o(front_value_o),
    .rear_value_o (rear_value_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  // clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  assign got_word = {accepted_o, front_value_o, rear_value_o, count_o, is_empty_o, is_full_o};

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor and watchdog on accepted input words and taken output words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        fifo_sb.note_word(kind_e'(kind_i), value_i);
      end
      if (out_valid_o && out_ready_i) begin
        fifo_sb.check_word(got_word);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic void set_idling(idle_mode_e mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 83 : ((mode == IDLE_BOTH) ? 12 : 0);
    stall_pct     = (mode == IDLE_RECEIVER) ? 83 : ((mode == IDLE_BOTH) ? 12 : 0);
  endfunction

  // operation mix, enqueue share set by the phase
  function automatic kind_e pick_kind(int enq_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return KIND_ENQ;
    if (r < 88) return KIND_DEQ;
    if (r < 96) return KIND_QRY;
    return KIND_BAD;
  endfunction

  // random payload with extremes mixed in
  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  // offer one word, with random gaps before it
  task automatic send_word(kind_e op, logic signed [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // wait for the block to drain, then write the capacity
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (fifo_sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    fifo_sb.set_capacity(cap);
  endtask

  // capacities per random phase: extremes, out-of-range and small rings
  logic [CAP_W-1:0] phase_cap [NUM_PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17,
                                                5'd2, 5'd5, 5'd16, 5'd9, 5'd3};

  // stimulus
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = CAP_RST;
    in_valid_i  = 1'b0;
    kind_i      = KIND_QRY;
    value_i     = '0;
    out_ready_i = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty corners, every kind and the value extremes
    set_idling(IDLE_BOTH);
    send_word(KIND_DEQ, rand_value());
    send_word(KIND_QRY, rand_value());
    send_word(KIND_BAD, rand_value());
    send_word(KIND_ENQ, 32'sh7fff_ffff);
    send_word(KIND_ENQ, 32'sh8000_0000);
    send_word(KIND_ENQ, -32'sd1);
    send_word(KIND_ENQ, 32'sd0);
    send_word(KIND_BAD, rand_value());
    send_word(KIND_DEQ, rand_value());
    send_word(KIND_QRY, rand_value());

    // capacity write on a non-empty queue, then full refusal and wrap
    write_capacity(5'd2);
    send_word(KIND_ENQ, 32'sh5555_5555);
    send_word(KIND_ENQ, 32'shaaaa_aaaa);
    send_word(KIND_ENQ, rand_value());
    send_word(KIND_DEQ, rand_value());
    send_word(KIND_ENQ, rand_value());
    send_word(KIND_QRY, rand_value());
    send_word(KIND_DEQ, rand_value());
    send_word(KIND_DEQ, rand_value());
    send_word(KIND_DEQ, rand_value());

    // random phases over capacities and idling patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      set_idling(idle_mode_e'(p % 4));
      if (p == 4) hold_request = HOLD_CYCLES;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(pick_kind((p % 2 == 0) ? 60 : 38), rand_value());
      end
    end
    in_valid_i <= 1'b0;

    // drain and let the pipeline settle
    while (fifo_sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fifo_sb.errors == 0 && fifo_sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/cfq_pkg.sv
sv/cfq_ctrl.sv
sv/cfq_dp.sv
sv/circular_fifo_queue.sv
sv/cfq_checker.sv
tb/sv/tb_circular_fifo_queue.sv
